@@ sv/cpds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clock prescaler divider search package
// Shared constants, controller state type and controller/datapath bundles.
// ----------------------------------------------------------------------------
package cpds_pkg;

    localparam int unsigned MAX_PRESCALER_DEF = 2048;
    localparam int unsigned MAX_DIVIDER_DEF   = 15;

    localparam int unsigned RATE_W     = 32;
    localparam int unsigned PRE_OUT_W  = 13;
    localparam int unsigned DIV_OUT_W  = 5;
    localparam int unsigned WORD_OUT_W = 17;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step_div;
        logic step_pre;
        logic fail;
        logic mark_hit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic last_div;
        logic last_pre;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ sv/cpds_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clock prescaler divider search datapath
// Holds the shifted source rate and a running multiple of the target rate
// plus one, and tests one prescaler and divider pair each cycle.
// ----------------------------------------------------------------------------
module cpds_dp #(
    parameter int unsigned MAX_PRESCALER = cpds_pkg::MAX_PRESCALER_DEF,
    parameter int unsigned MAX_DIVIDER   = cpds_pkg::MAX_DIVIDER_DEF
) (
    input  wire logic                                i_clk,
    input  wire cpds_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [cpds_pkg::RATE_W-1:0]         i_source_rate,
    input  wire logic [cpds_pkg::RATE_W-1:0]         i_target_rate,
    output cpds_pkg::t_dp_stat                       o_stat,
    output logic      [cpds_pkg::PRE_OUT_W-1:0]      o_prescaler,
    output logic      [cpds_pkg::DIV_OUT_W-1:0]      o_divider,
    output logic      [cpds_pkg::WORD_OUT_W-1:0]     o_rate_word,
    output logic                                     o_found
);

    localparam int unsigned PRE_W  = $clog2(MAX_PRESCALER + 1) + 1;
    localparam int unsigned DIV_W  = $clog2(MAX_DIVIDER + 2);
    localparam int unsigned TGT_W  = cpds_pkg::RATE_W + 1;
    localparam int unsigned ACC_W  = TGT_W + DIV_W;
    localparam int unsigned WORD_W = PRE_W + 4 + DIV_W;

    logic [cpds_pkg::RATE_W-1:0] r_src_sh;
    logic [TGT_W-1:0]            r_tgt1;
    logic [ACC_W-1:0]            r_acc;
    logic [DIV_W-1:0]            r_div;
    logic [PRE_W-1:0]            r_pre;
    logic                        r_found;

    logic [TGT_W-1:0]  n_tgt1;
    logic [PRE_W-1:0]  n_pre;
    logic [WORD_W-1:0] rate_word_w;

    assign n_tgt1 = {1'b0, i_target_rate} + TGT_W'(1);
    assign n_pre  = (r_pre == '0) ? PRE_W'(1) : {r_pre[PRE_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src_sh <= i_source_rate;
            r_tgt1   <= n_tgt1;
            r_acc    <= ACC_W'({n_tgt1, 1'b0});
            r_div    <= DIV_W'(1);
            r_pre    <= '0;
            r_found  <= 1'b0;
        end else if (i_cmd.step_div) begin
            r_acc <= r_acc + ACC_W'(r_tgt1);
            r_div <= r_div + DIV_W'(1);
        end else if (i_cmd.step_pre) begin
            r_src_sh <= {1'b0, r_src_sh[cpds_pkg::RATE_W-1:1]};
            r_acc    <= ACC_W'({r_tgt1, 1'b0});
            r_div    <= DIV_W'(1);
            r_pre    <= n_pre;
        end else if (i_cmd.fail) begin
            r_div <= DIV_W'(MAX_DIVIDER + 1);
            r_pre <= n_pre;
        end else if (i_cmd.mark_hit) begin
            r_found <= 1'b1;
        end
    end

    always_comb begin
        o_stat.hit      = ACC_W'(r_src_sh) < r_acc;
        o_stat.last_div = (r_div == DIV_W'(MAX_DIVIDER));
        o_stat.last_pre = (n_pre > PRE_W'(MAX_PRESCALER));
    end

    assign rate_word_w = {r_pre, 4'b0000, DIV_W'(0)} >> DIV_W | WORD_W'(r_div);
    assign o_prescaler = cpds_pkg::PRE_OUT_W'(r_pre);
    assign o_divider   = cpds_pkg::DIV_OUT_W'(r_div);
    assign o_rate_word = cpds_pkg::WORD_OUT_W'(rate_word_w);
    assign o_found     = r_found;

endmodule
`default_nettype wire

@@ sv/cpds_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clock prescaler divider search controller
// Sequences the load, the pair-by-pair search and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module cpds_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire cpds_pkg::t_dp_stat i_stat,
    output cpds_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy,
    output logic                    o_valid
);

    cpds_pkg::t_state r_state;
    cpds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            cpds_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = cpds_pkg::ST_SEARCH;
                end
            end
            cpds_pkg::ST_SEARCH: begin
                if (i_stat.hit) begin
                    o_cmd.mark_hit = 1'b1;
                    n_state        = cpds_pkg::ST_DONE;
                end else if (!i_stat.last_div) begin
                    o_cmd.step_div = 1'b1;
                end else if (!i_stat.last_pre) begin
                    o_cmd.step_pre = 1'b1;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = cpds_pkg::ST_DONE;
                end
            end
            cpds_pkg::ST_DONE: begin
                o_valid = 1'b1;
                n_state = cpds_pkg::ST_IDLE;
            end
            default: begin
                n_state = cpds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/clock_prescaler_divider_search.sv @@
// A taken request loads the datapath; the search state then tests pairs in order, and a fit
// or the last pair moves it to the done state, which strobes the result. Before the first fit
// 0 to 194 pairs fail at the default parameters; a search that finds no pair tests them all.
// One prescaler and divider pair is tested per cycle by an add and compare in the datapath.
// A new request is taken in the cycle after the strobe, once the controller is back in idle.
// Synchronous active-low reset returns the controller to idle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clock prescaler divider search
// Finds the first prescaler and divider pair whose output rate is at or below
// the requested rate.
// ----------------------------------------------------------------------------
module clock_prescaler_divider_search #(
    parameter int unsigned MAX_PRESCALER = cpds_pkg::MAX_PRESCALER_DEF,
    parameter int unsigned MAX_DIVIDER   = cpds_pkg::MAX_DIVIDER_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [cpds_pkg::RATE_W-1:0]         i_source_rate,
    input  wire logic [cpds_pkg::RATE_W-1:0]         i_target_rate,
    output logic                                     o_valid,
    output logic      [cpds_pkg::PRE_OUT_W-1:0]      o_prescaler,
    output logic      [cpds_pkg::DIV_OUT_W-1:0]      o_divider,
    output logic      [cpds_pkg::WORD_OUT_W-1:0]     o_rate_word,
    output logic                                     o_found
);

    cpds_pkg::t_dp_cmd  dp_cmd;
    cpds_pkg::t_dp_stat dp_stat;

    cpds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    cpds_dp #(
        .MAX_PRESCALER (MAX_PRESCALER),
        .MAX_DIVIDER   (MAX_DIVIDER)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .i_source_rate (i_source_rate),
        .i_target_rate (i_target_rate),
        .o_stat        (dp_stat),
        .o_prescaler   (o_prescaler),
        .o_divider     (o_divider),
        .o_rate_word   (o_rate_word),
        .o_found       (o_found)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe lasted more than one cycle.");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("Accepted request did not enter the search.");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("Result strobe while idle.");

    a_found_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_divider != '0))
        else $error("Found result carries a zero divider.");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock prescaler divider search testbench
// Sends source and target rate requests through the start/busy handshake,
// predicts the first prescaler and divider pair that meets each target, and
// checks every strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned PRINT_CAP    = 40;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned PRE_STEPS    = 12;
    localparam int unsigned RANDOM_COUNT = 360;

    typedef struct packed {
        logic [cpds_pkg::PRE_OUT_W-1:0]  prescaler;
        logic [cpds_pkg::DIV_OUT_W-1:0]  divider;
        logic [cpds_pkg::WORD_OUT_W-1:0] rate_word;
        logic                            found;
    } t_pair_result;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            start         = 1'b0;
    logic [cpds_pkg::RATE_W-1:0]     i_source_rate = '0;
    logic [cpds_pkg::RATE_W-1:0]     i_target_rate = '0;
    logic                            busy;
    logic                            o_valid;
    logic [cpds_pkg::PRE_OUT_W-1:0]  o_prescaler;
    logic [cpds_pkg::DIV_OUT_W-1:0]  o_divider;
    logic [cpds_pkg::WORD_OUT_W-1:0] o_rate_word;
    logic                            o_found;

    t_pair_result expected_pairs[$];
    t_pair_result head_pair;
    int           error_count = 0;
    int           idle_pct    = 0;
    int unsigned  cycle_count = 0;

    clock_prescaler_divider_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_source_rate (i_source_rate),
        .i_target_rate (i_target_rate),
        .o_valid       (o_valid),
        .o_prescaler   (o_prescaler),
        .o_divider     (o_divider),
        .o_rate_word   (o_rate_word),
        .o_found       (o_found)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned candidate_rate(input longint unsigned src,
                                                       input longint unsigned pre,
                                                       input longint unsigned div);
        longint unsigned rate;
        rate = src / (div + 1);
        if (pre != 0) begin
            rate = rate / (pre * 2);
        end
        return rate;
    endfunction

    function automatic t_pair_result search_divider_pair(
        input logic [cpds_pkg::RATE_W-1:0] src,
        input logic [cpds_pkg::RATE_W-1:0] tgt);
        longint unsigned pre;
        longint unsigned div;
        longint unsigned word;
        bit              hit;
        t_pair_result    res;
        pre = 0;
        div = 1;
        hit = 1'b0;
        while (!hit && pre <= cpds_pkg::MAX_PRESCALER_DEF) begin
            div = 1;
            while (!hit && div <= cpds_pkg::MAX_DIVIDER_DEF) begin
                if (candidate_rate(src, pre, div) <= tgt) begin
                    hit = 1'b1;
                end else begin
                    div++;
                end
            end
            if (!hit) begin
                pre = (pre == 0) ? 1 : (pre << 1);
            end
        end
        word          = (pre << 4) | div;
        res.prescaler = pre[cpds_pkg::PRE_OUT_W-1:0];
        res.divider   = div[cpds_pkg::DIV_OUT_W-1:0];
        res.rate_word = word[cpds_pkg::WORD_OUT_W-1:0];
        res.found     = hit;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("ERROR at %0t ns: %s", $realtime, msg);
        end
    endtask

    task automatic send_request(input logic [cpds_pkg::RATE_W-1:0] src,
                                input logic [cpds_pkg::RATE_W-1:0] tgt);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_source_rate <= src;
        i_target_rate <= tgt;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        expected_pairs.push_back(search_divider_pair(src, tgt));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("result strobe with no request pending");
            end else begin
                head_pair = expected_pairs.pop_front();
                if (o_prescaler !== head_pair.prescaler) begin
                    report_mismatch($sformatf("prescaler %0d, expected %0d",
                                              o_prescaler, head_pair.prescaler));
                end
                if (o_divider !== head_pair.divider) begin
                    report_mismatch($sformatf("divider %0d, expected %0d",
                                              o_divider, head_pair.divider));
                end
                if (o_rate_word !== head_pair.rate_word) begin
                    report_mismatch($sformatf("rate_word 0x%05h, expected 0x%05h",
                                              o_rate_word, head_pair.rate_word));
                end
                if (o_found !== head_pair.found) begin
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              o_found, head_pair.found));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic test_zero_rates();
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_search_failure();
        send_request(32'hFFFF_FFFF, 32'd65534);
        send_request(32'hFFFF_FFFF, 32'd65535);
        send_request(32'd1_000_000, 32'd0);
        send_request(32'd65535, 32'd0);
    endtask

    task automatic test_pair_boundaries();
        send_request(32'd200, 32'd100);
        send_request(32'd200, 32'd99);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_prescaler_steps();
        longint unsigned pre;
        longint unsigned rate;
        pre = 0;
        for (int k = 0; k < PRE_STEPS; k++) begin
            rate = candidate_rate(32'hFFFF_FFFF, pre, 8);
            send_request(32'hFFFF_FFFF, rate[cpds_pkg::RATE_W-1:0]);
            pre = (pre == 0) ? 1 : (pre << 1);
        end
    endtask

    task automatic test_random_requests(input int count, input int pct);
        logic [cpds_pkg::RATE_W-1:0] src;
        logic [cpds_pkg::RATE_W-1:0] tgt;
        longint unsigned             pre;
        longint unsigned             rate;
        int                          idx;
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            src = $urandom;
            if ($urandom_range(3) == 0) begin
                src = src >> $urandom_range(31);
            end
            idx  = $urandom_range(PRE_STEPS - 1);
            pre  = (idx == 0) ? 0 : (64'd1 << (idx - 1));
            rate = candidate_rate(src, pre, $urandom_range(1, cpds_pkg::MAX_DIVIDER_DEF));
            case ($urandom_range(9))
                0, 1, 2, 3: tgt = rate[cpds_pkg::RATE_W-1:0];
                4, 5:       tgt = (rate == 0) ? '0 : rate[cpds_pkg::RATE_W-1:0] - 1'b1;
                6:          tgt = rate[cpds_pkg::RATE_W-1:0] + $urandom_range(3);
                7:          tgt = $urandom;
                8:          tgt = $urandom_range(70000);
                default:    tgt = $urandom >> $urandom_range(31);
            endcase
            send_request(src, tgt);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        test_zero_rates();
        test_search_failure();
        test_pair_boundaries();
        test_prescaler_steps();
        test_random_requests(RANDOM_COUNT, 0);
        test_random_requests(RANDOM_COUNT, 64);
        test_random_requests(RANDOM_COUNT, 10);

        start <= 1'b0;
        while (expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
